// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is held
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- sv/owm_pkg.sv -----
`default_nettype none

package owm_pkg;

    // timer width default
    localparam int TIMER_BITS_DEF = 10;

    // configuration register width and count
    localparam int CFG_W   = 10;
    localparam int CFG_NUM = 8;
    localparam int CFG_IW  = $clog2(CFG_NUM);

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_RESET_LOW  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_PRES_WAIT  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_RESET_TAIL = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_W1_LOW     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_W0_LOW     = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_RD_LOW     = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_RD_SAMPLE  = 3'd6;
    localparam logic [CFG_IW-1:0] CFG_SLOT_LEN   = 3'd7;

    // configuration reset values
    localparam logic [CFG_W-1:0] RST_RESET_LOW  = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRES_WAIT  = 10'd70;
    localparam logic [CFG_W-1:0] RST_RESET_TAIL = 10'd410;
    localparam logic [CFG_W-1:0] RST_W1_LOW     = 10'd6;
    localparam logic [CFG_W-1:0] RST_W0_LOW     = 10'd60;
    localparam logic [CFG_W-1:0] RST_RD_LOW     = 10'd6;
    localparam logic [CFG_W-1:0] RST_RD_SAMPLE  = 10'd9;
    localparam logic [CFG_W-1:0] RST_SLOT_LEN   = 10'd70;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // timing registers as seen by the bus engine
    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] presence_wait_time;
        logic [CFG_W-1:0] reset_tail_time;
        logic [CFG_W-1:0] write_one_low_time;
        logic [CFG_W-1:0] write_zero_low_time;
        logic [CFG_W-1:0] read_low_time;
        logic [CFG_W-1:0] read_sample_delay;
        logic [CFG_W-1:0] slot_length;
    } cfg_t;

    // one result per tick
    typedef struct packed {
        logic       cmd_rejected;
        logic [7:0] rx_byte;
        logic       device_present;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } res_t;

endpackage

`default_nettype wire

// ----- sv/owm_cfg.sv -----
`default_nettype none

module owm_cfg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [owm_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [owm_pkg::CFG_W-1:0]  cfg_data,
    output owm_pkg::cfg_t                  cfg
);
    import owm_pkg::*;

    cfg_t cfg_reg;

    // register file, written one register a transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_time      <= RST_RESET_LOW;
            cfg_reg.presence_wait_time  <= RST_PRES_WAIT;
            cfg_reg.reset_tail_time     <= RST_RESET_TAIL;
            cfg_reg.write_one_low_time  <= RST_W1_LOW;
            cfg_reg.write_zero_low_time <= RST_W0_LOW;
            cfg_reg.read_low_time       <= RST_RD_LOW;
            cfg_reg.read_sample_delay   <= RST_RD_SAMPLE;
            cfg_reg.slot_length         <= RST_SLOT_LEN;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RESET_LOW:  cfg_reg.reset_low_time      <= cfg_data;
                CFG_PRES_WAIT:  cfg_reg.presence_wait_time  <= cfg_data;
                CFG_RESET_TAIL: cfg_reg.reset_tail_time     <= cfg_data;
                CFG_W1_LOW:     cfg_reg.write_one_low_time  <= cfg_data;
                CFG_W0_LOW:     cfg_reg.write_zero_low_time <= cfg_data;
                CFG_RD_LOW:     cfg_reg.read_low_time       <= cfg_data;
                CFG_RD_SAMPLE:  cfg_reg.read_sample_delay   <= cfg_data;
                CFG_SLOT_LEN:   cfg_reg.slot_length         <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/owm_core.sv -----
`default_nettype none

module owm_core #(
    parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step,
    input  wire logic [1:0]    cmd,
    input  wire logic [7:0]    tx_byte,
    input  wire logic          line_level,
    input  wire owm_pkg::cfg_t cfg,
    output owm_pkg::res_t      res,
    output logic               idle
);
    import owm_pkg::*;

    // length arithmetic wide enough for both timer and register values
    localparam int LW = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;
    localparam logic [LW-1:0] LEN_MAX    = LW'(1) << TIMER_BITS;
    localparam logic [LW-1:0] SAMPLE_MAX = LEN_MAX - LW'(1);

    // phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_LOW  = 3'd1;
    localparam logic [2:0] PH_RST_WAIT = 3'd2;
    localparam logic [2:0] PH_RST_TAIL = 3'd3;
    localparam logic [2:0] PH_SLOT_LOW = 3'd4;
    localparam logic [2:0] PH_SLOT_REL = 3'd5;

    logic [2:0]            phase_reg,    phase_next;
    logic [1:0]            op_reg,       op_next;
    logic [TIMER_BITS-1:0] timer_reg,    timer_next;
    logic [2:0]            bit_reg,      bit_next;
    logic [7:0]            shift_reg,    shift_next;
    logic                  presence_reg, presence_next;
    logic [7:0]            last_rd_reg,  last_rd_next;

    logic          drive, busy, done, rej, last;
    logic [LW-1:0] low_len, len, sample, minimum, rest, slot_len, timer_inc;

    // zero counts as one tick, long lengths saturate at the timer range
    function automatic logic [LW-1:0] eff_len(input logic [LW-1:0] l);
        logic [LW-1:0] r;
        r = l;
        if (r == '0) r = LW'(1);
        if (r > LEN_MAX) r = LEN_MAX;
        return r;
    endfunction

    // per-tick state update
    always_comb begin
        phase_next    = phase_reg;
        op_next       = op_reg;
        timer_next    = timer_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        last_rd_next  = last_rd_reg;
        drive   = 1'b0;
        done    = 1'b0;
        rej     = 1'b0;
        len     = LW'(1);
        last    = 1'b0;
        sample  = '0;
        minimum = LW'(1);
        rest    = '0;

        // command start; the start tick is already the first tick of the operation
        if (phase_reg == PH_IDLE) begin
            if (cmd != CMD_TICK) begin
                op_next    = cmd;
                timer_next = '0;
                bit_next   = '0;
                shift_next = (cmd == CMD_WRITE) ? tx_byte : 8'h00;
                phase_next = (cmd == CMD_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
            end
        end else if (cmd != CMD_TICK) begin
            rej = 1'b1;
        end
        busy = (phase_next != PH_IDLE);

        // slot low time follows the bit being sent on a write; a read uses the read low time
        if (op_next == CMD_WRITE) begin
            low_len = eff_len(LW'(shift_next[0] ? cfg.write_one_low_time
                                                : cfg.write_zero_low_time));
        end else begin
            low_len = eff_len(LW'(cfg.read_low_time));
        end

        // release part of the slot
        if (LW'(cfg.read_sample_delay) > SAMPLE_MAX) begin
            sample = SAMPLE_MAX;
        end else begin
            sample = LW'(cfg.read_sample_delay);
        end
        if (op_next == CMD_READ) begin
            minimum = sample + LW'(1);
        end
        slot_len = LW'(cfg.slot_length);
        if (slot_len > low_len) begin
            rest = slot_len - low_len;
        end
        if (rest < minimum) begin
            rest = minimum;
        end

        // phase length
        case (phase_next)
            PH_RST_LOW:  len = eff_len(LW'(cfg.reset_low_time));
            PH_RST_WAIT: len = eff_len(LW'(cfg.presence_wait_time));
            PH_RST_TAIL: len = eff_len(LW'(cfg.reset_tail_time));
            PH_SLOT_LOW: len = low_len;
            PH_SLOT_REL: len = eff_len(rest);
            default:     len = LW'(1);
        endcase
        timer_inc = LW'(timer_next) + LW'(1);
        last      = (timer_inc >= len);

        // phase actions
        case (phase_next)
            PH_IDLE: ;
            PH_RST_LOW: begin
                drive = 1'b1;
                if (last) phase_next = PH_RST_WAIT;
            end
            PH_RST_WAIT: begin
                if (last) phase_next = PH_RST_TAIL;
            end
            PH_RST_TAIL: begin
                if (timer_next == '0) presence_next = ~line_level;
                if (last) begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_SLOT_LOW: begin
                drive = 1'b1;
                if (last) phase_next = PH_SLOT_REL;
            end
            PH_SLOT_REL: begin
                if (op_next == CMD_READ && LW'(timer_next) == sample) begin
                    shift_next = {line_level, shift_next[7:1]};
                end
                if (last) begin
                    if (bit_next == 3'd7) begin
                        done = 1'b1;
                        if (op_next == CMD_READ) last_rd_next = shift_next;
                        phase_next = PH_IDLE;
                        bit_next   = '0;
                    end else begin
                        bit_next = bit_next + 3'd1;
                        if (op_next == CMD_WRITE) shift_next = {1'b0, shift_next[7:1]};
                        phase_next = PH_SLOT_LOW;
                    end
                end
            end
            default: phase_next = PH_IDLE;
        endcase

        // timer runs in every timed phase
        if (phase_reg != PH_IDLE || cmd != CMD_TICK) begin
            timer_next = last ? '0 : TIMER_BITS'(timer_inc);
        end

        res.drive_low      = drive;
        res.busy_res       = busy;
        res.done_res       = done;
        res.device_present = presence_next;
        res.rx_byte        = last_rd_next;
        res.cmd_rejected   = rej;
    end

    assign idle = (phase_reg == PH_IDLE);

    // state registers, one update per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            op_reg       <= '0;
            timer_reg    <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            last_rd_reg  <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            op_reg       <= op_next;
            timer_reg    <= timer_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            last_rd_reg  <= last_rd_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/one_wire_bus_master.sv -----
// 1-Wire bus master driven by a stream of microsecond ticks. Every transfer in carries the
// sampled line level and, while the master is idle, an optional command (bus reset, write
// byte, read byte); every tick gives exactly one result transfer with the line drive, busy,
// done, presence and last received byte. One tick is accepted per clock cycle, sustained while
// the result output is not held by m_tready, and its result passes the input register, then the
// core state update into the output register; the throughput is set by the one update of the
// bus state per tick. Timing lengths come from eight 10-bit registers written through the
// cfg port, which may only be written while no tick is in flight.
`default_nettype none

module one_wire_bus_master #(
    parameter int TIMER_BITS = owm_pkg::TIMER_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration writes
    input  wire logic                       cfg_wr_en,
    input  wire logic [owm_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [owm_pkg::CFG_W-1:0]  cfg_data,
    // tick input
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [15:0]                s_tdata,  // tx_byte[7:0], line_level[8], zero
    input  wire logic [1:0]                 s_tuser,  // cmd[1:0]
    // result output
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // drive_low[0], busy_res[1], done_res[2], device_present[3], rx_byte[11:4],
    // cmd_rejected[12], zero
    output logic [15:0]                     m_tdata
);
    import owm_pkg::*;

    `include "assert_macros.svh"

    logic       in_vld_reg;
    logic [1:0] in_cmd_reg;
    logic [7:0] in_tx_reg;
    logic       in_lvl_reg;
    logic       out_vld_reg;
    res_t       out_res_reg;

    cfg_t cfg;
    res_t core_res;
    logic core_idle;
    logic adv;
    logic step;

    // output stage may move when it is empty or being taken
    assign adv      = !out_vld_reg || m_tready;
    assign step     = adv && in_vld_reg;
    assign s_tready = !in_vld_reg || adv;

    owm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .cmd        (in_cmd_reg),
        .tx_byte    (in_tx_reg),
        .line_level (in_lvl_reg),
        .cfg        (cfg),
        .res        (core_res),
        .idle       (core_idle)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg <= s_tuser;
            in_tx_reg  <= s_tdata[7:0];
            in_lvl_reg <= s_tdata[8];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_res_reg};

    // the line is only pulled low inside an operation
    `ASSERT_IMPLY(a_drive_busy, aclk, aresetn, out_vld_reg && out_res_reg.drive_low, out_res_reg.busy_res)
    // a bus reset started from idle pulls the line low on its first tick
    `ASSERT_NEXT(a_reset_starts, aclk, aresetn, step && core_idle && (in_cmd_reg == CMD_RESET), out_vld_reg && out_res_reg.drive_low && out_res_reg.busy_res && !out_res_reg.cmd_rejected)
    // a plain tick is never flagged as rejected
    `ASSERT_NEXT(a_tick_not_rej, aclk, aresetn, step && (in_cmd_reg == CMD_TICK), !out_res_reg.cmd_rejected)

endmodule

`default_nettype wire
